// ----- design/iis_pkg.sv -----
// iis_pkg: shared constants and types for the streaming integral image block
// no dependencies; imported by iis_track, iis_line_store and integral_image_stream
`timescale 1ns / 1ps

package iis_pkg;

   localparam int PIX_W          = 8;
   localparam int AREA_W         = 28;
   localparam int CSR_W          = 11;
   localparam int REQ_DATA_W     = 8;
   localparam int RSP_DATA_W     = 32;
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   // per-pixel position flags handed from the tracker to the pipeline
   typedef struct packed {
      logic first_row;
      logic overflow;
   } iis_flag_type;

endpackage

// ----- design/iis_track.sv -----
// iis_track: column, row and running row-sum tracking for each accepted pixel
// depends on iis_pkg
`timescale 1ns / 1ps

module iis_track #(
   parameter int MAX_WIDTH  = iis_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = iis_pkg::DEF_MAX_HEIGHT,
   parameter int AW         = $clog2(MAX_WIDTH),
   parameter int CLW        = $clog2(MAX_WIDTH + 1),
   parameter int RSW        = $clog2(MAX_WIDTH * 255 + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        take,
   input  logic [iis_pkg::PIX_W-1:0]   pixel,
   input  logic                        start,
   input  logic [CLW-1:0]              eff_width,
   output logic [AW-1:0]               cur_col,
   output logic [RSW-1:0]              cur_rsum,
   output iis_pkg::iis_flag_type       cur_flags
);
   import iis_pkg::*;

   localparam int RW = $clog2(MAX_HEIGHT + 1);

   logic [CLW-1:0] col_ff, col_in, base_col;
   logic [RW-1:0]  row_ff, row_in;
   logic [RSW-1:0] rsum_ff, rsum_in, base_rsum;
   logic           wrap;

   always_comb begin
      wrap = !start && (col_ff >= eff_width);
      if (start || wrap) begin
         base_col  = '0;
         base_rsum = '0;
      end else begin
         base_col  = col_ff;
         base_rsum = rsum_ff;
      end
      if (start) begin
         row_in = '0;
      end else if (wrap && (row_ff != RW'(MAX_HEIGHT))) begin
         row_in = row_ff + RW'(1);
      end else begin
         row_in = row_ff;
      end
      rsum_in             = base_rsum + RSW'(pixel);
      col_in              = base_col + CLW'(1);
      cur_col             = base_col[AW-1:0];
      cur_rsum            = rsum_in;
      cur_flags.first_row = (row_in == '0);
      cur_flags.overflow  = (row_in == RW'(MAX_HEIGHT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         rsum_ff <= '0;
      end else if (take) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         rsum_ff <= rsum_in;
      end
   end

endmodule

// ----- design/iis_line_store.sv -----
// iis_line_store: previous-row integral memory, one write and one registered read port
// depends on iis_pkg; sweeps zeros through every entry after reset
`timescale 1ns / 1ps

module iis_line_store #(
   parameter int MAX_WIDTH = iis_pkg::DEF_MAX_WIDTH,
   parameter int AW        = $clog2(MAX_WIDTH)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   output logic [iis_pkg::AREA_W-1:0]  rd_data,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [iis_pkg::AREA_W-1:0]  wr_data,
   output logic                        busy
);
   import iis_pkg::*;

   logic [AREA_W-1:0] ram [MAX_WIDTH];
   logic [AREA_W-1:0] rd_data_ff;
   logic              clr_active_ff;
   logic [AW-1:0]     clr_addr_ff;
   logic              we;
   logic [AW-1:0]     wa;
   logic [AREA_W-1:0] wd;

   // clearing sweep owns the write port while active
   always_comb begin
      we = clr_active_ff || wr_en;
      wa = clr_active_ff ? clr_addr_ff : wr_addr;
      wd = clr_active_ff ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(MAX_WIDTH - 1)) begin
            clr_active_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         ram[wa] <= wd;
      end
      if (rd_en) begin
         rd_data_ff <= ram[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_active_ff;

endmodule

// ----- design/integral_image_stream.sv -----
// integral_image_stream: streaming summed-area table, one pixel word in, one sum word out
// depends on iis_pkg, iis_track and iis_line_store
`timescale 1ns / 1ps

//  channel   | direction | payload
//  ----------+-----------+-------------------------------------------------
//  req_*     | in        | tdata[7:0] pixel_value, tuser frame_start
//  rsp_*     | out       | tdata[27:0] area_sum (rest zero), tuser height_overflow
//  csr_*     | in        | wr_data row_width, taken whenever wr_en is high
//
//  one pixel word per clock sustained while rsp_tready holds and no clear runs; an
//  accepted word is registered in the sum stage (line store data, sum + write-back)
//  and is then loaded into the output register, which drives rsp_tvalid
//  the line store gives one read and one write per cycle, which sets the rate
//  after reset the line store is zeroed entry by entry with req_tready low
//  rsp stalls fill the sum stage and then lower req_tready; nothing is dropped

module integral_image_stream #(
   parameter int MAX_WIDTH  = iis_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = iis_pkg::DEF_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   // input pixel words
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [iis_pkg::REQ_DATA_W-1:0]  req_tdata,   // [7:0] pixel_value
   input  logic                            req_tuser,   // frame_start
   // result words
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [iis_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // [27:0] area_sum, [31:28] zero
   output logic                            rsp_tuser,   // height_overflow
   // row width register
   input  logic                            csr_wr_en,
   input  logic [iis_pkg::CSR_W-1:0]       csr_wr_data
);
   import iis_pkg::*;

   localparam int AW  = $clog2(MAX_WIDTH);
   localparam int CLW = $clog2(MAX_WIDTH + 1);
   localparam int RSW = $clog2(MAX_WIDTH * 255 + 1);
   localparam int EW  = (CLW > CSR_W) ? CLW : CSR_W;

   // effective width, clamped to 1..MAX_WIDTH when written
   logic [CLW-1:0] width_ff, width_in;
   logic [EW-1:0]  csr_ext;

   always_comb begin
      csr_ext = EW'(csr_wr_data);
      if (csr_ext == '0) begin
         width_in = CLW'(1);
      end else if (csr_ext > EW'(MAX_WIDTH)) begin
         width_in = CLW'(MAX_WIDTH);
      end else begin
         width_in = csr_ext[CLW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= CLW'(MAX_WIDTH);
      end else if (csr_wr_en) begin
         width_ff <= width_in;
      end
   end

   // handshake
   logic take, s1_adv, busy;
   logic s1_valid_ff;
   logic out_valid_ff;

   assign s1_adv     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !busy && (!s1_valid_ff || s1_adv);
   assign take       = req_tvalid && req_tready;

   // position tracking for the word being accepted
   logic [AW-1:0]  cur_col;
   logic [RSW-1:0] cur_rsum;
   iis_flag_type   cur_flags;

   iis_track #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .AW         (AW),
      .CLW        (CLW),
      .RSW        (RSW)
   ) u_track (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .pixel     (req_tdata[PIX_W-1:0]),
      .start     (req_tuser),
      .eff_width (width_ff),
      .cur_col   (cur_col),
      .cur_rsum  (cur_rsum),
      .cur_flags (cur_flags)
   );

   // sum stage: the line store read issued on accept lands here
   logic [AW-1:0]     s1_col_ff;
   logic [RSW-1:0]    s1_rsum_ff;
   iis_flag_type      s1_flags_ff;
   logic              fwd_ff;
   logic [AREA_W-1:0] fwd_data_ff;
   logic [AREA_W-1:0] rd_data, above, sum;

   // a single-pixel row reads the entry the sum stage writes in the same cycle
   always_comb begin
      if (s1_flags_ff.first_row) begin
         above = '0;
      end else if (fwd_ff) begin
         above = fwd_data_ff;
      end else begin
         above = rd_data;
      end
      sum = AREA_W'(s1_rsum_ff) + above;
   end

   iis_line_store #(
      .MAX_WIDTH (MAX_WIDTH),
      .AW        (AW)
   ) u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (take),
      .rd_addr (cur_col),
      .rd_data (rd_data),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (sum),
      .busy    (busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_col_ff   <= cur_col;
         s1_rsum_ff  <= cur_rsum;
         s1_flags_ff <= cur_flags;
         fwd_ff      <= s1_adv && (s1_col_ff == cur_col);
         fwd_data_ff <= sum;
      end
   end

   // output register
   logic [AREA_W-1:0] out_sum_ff;
   logic              out_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_sum_ff <= sum;
         out_ovf_ff <= s1_flags_ff.overflow;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_sum_ff);
   assign rsp_tuser  = out_ovf_ff;

   // no word is taken while the line store is being cleared
   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      busy |-> !take)
      else $error("pixel accepted during line store clear");

   // a held sum stage keeps its column and running sum
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> ($stable(s1_col_ff) && $stable(s1_rsum_ff)))
      else $error("sum stage changed while stalled");

   // first row of a frame can never be past the height limit
   a_flags: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !(s1_flags_ff.first_row && s1_flags_ff.overflow))
      else $error("first row flagged as height overflow");

   // the sum stage only advances into a free or draining output register
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      s1_adv |-> (!out_valid_ff || rsp_tready))
      else $error("output register overwritten");

   // nothing shows on the result side right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule
